FILE: hdl/fat_volume_layout_calc_top_defines.svh
// Assertion macros for the FAT layout calculator top level.
// Depends on nothing; expects i_clk and i_rst_n in the including scope.
`ifndef FAT_VOLUME_LAYOUT_CALC_TOP_DEFINES_SVH
`define FAT_VOLUME_LAYOUT_CALC_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, idle during reset
`define FVL_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("layout calculator: same-cycle check failed");

// Next-cycle implication, sampled on the rising edge, idle during reset
`define FVL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("layout calculator: next-cycle check failed");

`endif

FILE: hdl/fvl_pkg.sv
// Shared types, constants and the microcode table of the FAT layout calculator.
// Used by fvl_dp, fvl_seq and fat_volume_layout_calc_top; depends on nothing.
package fvl_pkg;

    // Limits and defaults of the FAT12/16 layout rules
    localparam int unsigned FVL_MAX_RETRIES = 16;
    localparam logic [31:0] FAT12_LIMIT     = 32'h0000_0FF5;
    localparam logic [31:0] FAT16_LIMIT     = 32'h0000_FFF5;
    localparam logic [15:0] DEFAULT_ROOT    = 16'd224;
    localparam logic [7:0]  MEDIA_HARD      = 8'hF8;
    localparam logic [7:0]  MEDIA_FLOPPY    = 8'hF0;
    localparam logic [7:0]  DRIVE_HARD      = 8'h80;
    localparam logic [7:0]  DRIVE_FLOPPY    = 8'h00;
    localparam logic [31:0] HEAD_FAT12      = 32'h00FF_FF00;
    localparam logic [31:0] HEAD_FAT16      = 32'hFFFF_FF00;

    // Automatic cluster size: thresholds on volume size in 2 MiB units
    localparam int           SIZE_STEP_N = 6;
    localparam logic [19:0]  SIZE_STEPS [SIZE_STEP_N] = '{
        20'd1, 20'd4, 20'd16, 20'd64, 20'd256, 20'd512
    };

    typedef enum logic [2:0] {
        STAT_FAT12    = 3'd0,
        STAT_FAT16    = 3'd1,
        STAT_INVALID  = 3'd2,
        STAT_TOO_MANY = 3'd3,
        STAT_TOO_SMALL = 3'd4,
        STAT_NO_CONV  = 3'd5
    } t_status;

    // Datapath operations, one per microcode step
    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_PREP     = 4'd1,
        OP_DIV      = 4'd2,
        OP_FATSZ    = 4'd3,
        OP_REMAIN   = 4'd4,
        OP_FINAL    = 4'd5,
        OP_ADJUST   = 4'd6,
        OP_EMIT     = 4'd7,
        OP_ERR_INV  = 4'd8,
        OP_ERR_MANY = 4'd9,
        OP_ERR_SMALL = 4'd10,
        OP_ERR_CONV = 4'd11
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_INVALID  = 3'd2,
        C_OVER16   = 3'd3,
        C_SMALL    = 3'd4,
        C_NO_RETRY = 3'd5,
        C_EXHAUST  = 3'd6,
        C_OUT_BUSY = 3'd7
    } t_cond;

    typedef logic [3:0] t_step;

    // Program addresses
    localparam t_step S_PREP  = 4'd0;
    localparam t_step S_DIV   = 4'd1;
    localparam t_step S_FAT   = 4'd2;
    localparam t_step S_ROOM  = 4'd3;
    localparam t_step S_FINAL = 4'd4;
    localparam t_step S_CHK   = 4'd5;
    localparam t_step S_LIM   = 4'd6;
    localparam t_step S_ADJ   = 4'd7;
    localparam t_step S_DONE  = 4'd8;
    localparam t_step S_ERR2  = 4'd9;
    localparam t_step S_ERR3  = 4'd10;
    localparam t_step S_ERR4  = 4'd11;
    localparam t_step S_ERR5  = 4'd12;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
        logic  last;
    } t_uword;

    // Condition flags from the datapath
    typedef struct packed {
        logic invalid;
        logic over16;
        logic small_vol;
        logic no_retry;
        logic exhaust;
    } t_dp_flags;

    // Sequencer to datapath and top level
    typedef struct packed {
        t_op  op;
        logic busy;
    } t_ctrl;

    // Microcode ROM: operation, jump condition, jump target, end of program
    function automatic t_uword fvl_ucode(input t_step step);
        t_uword w;
        w = '{op: OP_NOP, cond: C_NEVER, target: S_DONE, last: 1'b1};
        unique case (step)
            S_PREP:  w = '{op: OP_PREP,      cond: C_INVALID,  target: S_ERR2, last: 1'b0};
            S_DIV:   w = '{op: OP_DIV,       cond: C_NEVER,    target: S_DIV,  last: 1'b0};
            S_FAT:   w = '{op: OP_FATSZ,     cond: C_OVER16,   target: S_ERR3, last: 1'b0};
            S_ROOM:  w = '{op: OP_REMAIN,    cond: C_SMALL,    target: S_ERR4, last: 1'b0};
            S_FINAL: w = '{op: OP_FINAL,     cond: C_NEVER,    target: S_FINAL, last: 1'b0};
            S_CHK:   w = '{op: OP_NOP,       cond: C_NO_RETRY, target: S_DONE, last: 1'b0};
            S_LIM:   w = '{op: OP_NOP,       cond: C_EXHAUST,  target: S_ERR5, last: 1'b0};
            S_ADJ:   w = '{op: OP_ADJUST,    cond: C_ALWAYS,   target: S_DIV,  last: 1'b0};
            S_DONE:  w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: S_DONE, last: 1'b1};
            S_ERR2:  w = '{op: OP_ERR_INV,   cond: C_ALWAYS,   target: S_DONE, last: 1'b0};
            S_ERR3:  w = '{op: OP_ERR_MANY,  cond: C_ALWAYS,   target: S_DONE, last: 1'b0};
            S_ERR4:  w = '{op: OP_ERR_SMALL, cond: C_ALWAYS,   target: S_DONE, last: 1'b0};
            S_ERR5:  w = '{op: OP_ERR_CONV,  cond: C_ALWAYS,   target: S_DONE, last: 1'b0};
            default: w = '{op: OP_NOP,       cond: C_NEVER,    target: S_DONE, last: 1'b1};
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/fat_volume_layout_calc_top.sv
// Each request runs the microcode program with r retries (0..MAX_RETRIES) of the cluster size;
// running out of retries ends in the no-convergence error status.
// One datapath step per cycle, set by the microcode program; the done step repeats while the result is held.
// A new request is taken only once the sequencer is idle; a held result stalls only the done step.
// Reset: synchronous, active low; clears the sequencer and the result valid flag.
// Depends on fvl_pkg, fvl_seq, fvl_dp and fat_volume_layout_calc_top_defines.svh.
`include "fat_volume_layout_calc_top_defines.svh"
module fat_volume_layout_calc_top
    import fvl_pkg::*;
#(
    parameter int unsigned MAX_RETRIES = FVL_MAX_RETRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_volume_start,
    input  logic [31:0] i_volume_sectors,
    input  logic [7:0]  i_cluster_sectors_req,
    input  logic [15:0] i_root_entries_req,
    input  logic [15:0] i_head_count,
    input  logic [15:0] i_track_sectors,
    input  logic [31:0] i_hidden_offset,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_sectors_per_cluster,
    output logic [15:0] o_root_entries,
    output logic [9:0]  o_fat_sectors,
    output logic [11:0] o_root_dir_sectors,
    output logic [31:0] o_fat_first_sector,
    output logic [15:0] o_cluster_count,
    output logic [31:0] o_hidden_sectors,
    output logic [7:0]  o_media_code,
    output logic [7:0]  o_drive_number,
    output logic [31:0] o_fat_head_word
);

    t_ctrl     ctrl;
    t_dp_flags flags;
    logic      accept, out_busy, emit;
    logic      r_out_valid, n_out_valid;

    logic [2:0]  d_status;
    logic [7:0]  d_spc, d_media, d_drive;
    logic [15:0] d_roots, d_clus;
    logic [9:0]  d_fat;
    logic [11:0] d_dir;
    logic [31:0] d_first, d_hidden, d_head;

    logic [2:0]  r_status;
    logic [7:0]  r_spc, r_media, r_drive;
    logic [15:0] r_roots, r_clus;
    logic [9:0]  r_fat;
    logic [11:0] r_dir;
    logic [31:0] r_first, r_hidden, r_head;

    // Take a request only while the sequencer is idle
    assign o_in_stall = ctrl.busy;
    assign accept     = i_in_valid && !ctrl.busy;

    // Hold the done step while the previous result is still stalled
    assign out_busy = r_out_valid && i_out_stall;
    assign emit     = (ctrl.op == OP_EMIT) && !out_busy;

    fvl_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_out_busy (out_busy),
        .i_flags    (flags),
        .o_ctrl     (ctrl)
    );

    fvl_dp #(
        .MAX_RETRIES (MAX_RETRIES)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_load                (accept),
        .i_op                  (ctrl.op),
        .i_volume_start        (i_volume_start),
        .i_volume_sectors      (i_volume_sectors),
        .i_cluster_sectors_req (i_cluster_sectors_req),
        .i_root_entries_req    (i_root_entries_req),
        .i_head_count          (i_head_count),
        .i_track_sectors       (i_track_sectors),
        .i_hidden_offset       (i_hidden_offset),
        .o_flags               (flags),
        .o_status              (d_status),
        .o_sectors_per_cluster (d_spc),
        .o_root_entries        (d_roots),
        .o_fat_sectors         (d_fat),
        .o_root_dir_sectors    (d_dir),
        .o_fat_first_sector    (d_first),
        .o_cluster_count       (d_clus),
        .o_hidden_sectors      (d_hidden),
        .o_media_code          (d_media),
        .o_drive_number        (d_drive),
        .o_fat_head_word       (d_head)
    );

    // Result valid: set on emit, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= d_status;
            r_spc    <= d_spc;
            r_roots  <= d_roots;
            r_fat    <= d_fat;
            r_dir    <= d_dir;
            r_first  <= d_first;
            r_clus   <= d_clus;
            r_hidden <= d_hidden;
            r_media  <= d_media;
            r_drive  <= d_drive;
            r_head   <= d_head;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_status;
    assign o_sectors_per_cluster = r_spc;
    assign o_root_entries        = r_roots;
    assign o_fat_sectors         = r_fat;
    assign o_root_dir_sectors    = r_dir;
    assign o_fat_first_sector    = r_first;
    assign o_cluster_count       = r_clus;
    assign o_hidden_sectors      = r_hidden;
    assign o_media_code          = r_media;
    assign o_drive_number        = r_drive;
    assign o_fat_head_word       = r_head;

    // Checks
    `FVL_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `FVL_ASSERT_IMPLIES(a_error_zeroes, o_out_valid && o_status != STAT_FAT12 && o_status != STAT_FAT16, o_cluster_count == 16'd0 && o_sectors_per_cluster == 8'd0)
    `FVL_ASSERT_IMPLIES(a_fat16_count, o_out_valid && o_status == STAT_FAT16, o_cluster_count > 16'h0FF5)
    `FVL_ASSERT_IMPLIES(a_fat12_count, o_out_valid && o_status == STAT_FAT12, o_cluster_count <= 16'h0FF5)

endmodule

FILE: hdl/fvl_dp.sv
// Datapath of the FAT layout calculator: request registers, cluster maths, result fields.
// Depends on fvl_pkg; driven one operation per cycle by fvl_seq.
module fvl_dp
    import fvl_pkg::*;
#(
    parameter int unsigned MAX_RETRIES = FVL_MAX_RETRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_op         i_op,
    input  logic [31:0] i_volume_start,
    input  logic [31:0] i_volume_sectors,
    input  logic [7:0]  i_cluster_sectors_req,
    input  logic [15:0] i_root_entries_req,
    input  logic [15:0] i_head_count,
    input  logic [15:0] i_track_sectors,
    input  logic [31:0] i_hidden_offset,
    output t_dp_flags   o_flags,
    output logic [2:0]  o_status,
    output logic [7:0]  o_sectors_per_cluster,
    output logic [15:0] o_root_entries,
    output logic [9:0]  o_fat_sectors,
    output logic [11:0] o_root_dir_sectors,
    output logic [31:0] o_fat_first_sector,
    output logic [15:0] o_cluster_count,
    output logic [31:0] o_hidden_sectors,
    output logic [7:0]  o_media_code,
    output logic [7:0]  o_drive_number,
    output logic [31:0] o_fat_head_word
);

    localparam int RW = $clog2(MAX_RETRIES + 1);

    // Request registers
    logic [31:0] r_vstart, r_vsize, r_hoff;
    logic [7:0]  r_creq;
    logic [15:0] r_rreq, r_heads, r_spt;

    // Working registers
    logic [2:0]    r_sh, n_sh;
    logic [15:0]   r_roots, n_roots;
    logic [11:0]   r_dir, n_dir;
    logic [31:0]   r_clus, n_clus;
    logic [31:0]   r_rem, n_rem;
    logic [9:0]    r_fat, n_fat;
    logic          r_fat16, n_fat16;
    logic [RW-1:0] r_retries, n_retries;
    logic          r_err, n_err;
    t_status       r_status, n_status;

    logic [2:0]  auto_sh, req_sh;
    logic [19:0] size_n;
    logic [15:0] roots_rnd;
    logic [16:0] clus_c;
    logic [19:0] bytes16, bytes12, fat_bytes;
    logic [10:0] fat_secs;
    logic [13:0] meta_secs;
    logic [14:0] need;
    logic        start_hard;
    t_status     res_status;

    // Capture the request at acceptance
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vstart <= i_volume_start;
            r_vsize  <= i_volume_sectors;
            r_creq   <= i_cluster_sectors_req;
            r_rreq   <= i_root_entries_req;
            r_heads  <= i_head_count;
            r_spt    <= i_track_sectors;
            r_hoff   <= i_hidden_offset;
        end
    end

    // Automatic cluster shift: count size thresholds reached
    always_comb begin
        size_n  = r_vsize[31:12];
        auto_sh = 3'd0;
        for (int k = 0; k < SIZE_STEP_N; k++) begin
            if (SIZE_STEPS[k] <= size_n) begin
                auto_sh = 3'(k + 1);
            end
        end
    end

    // Requested cluster shift: position of the single set bit
    always_comb begin
        req_sh = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (r_creq[i]) begin
                req_sh = 3'(i);
            end
        end
    end

    // Round root entries down to a multiple of sixteen, default when nothing is left
    always_comb begin
        roots_rnd = {r_rreq[15:4], 4'd0};
        if (roots_rnd == 16'd0) begin
            roots_rnd = DEFAULT_ROOT;
        end
    end

    // FAT size in sectors from the guessed cluster count
    assign clus_c    = r_clus[16:0];
    assign bytes16   = {2'd0, clus_c, 1'b0} + 20'd4;
    assign bytes12   = ((({2'd0, clus_c, 1'b0} + 20'(clus_c)) + 20'd1) >> 1) + 20'd3;
    assign fat_bytes = (r_clus > FAT12_LIMIT) ? bytes16 : bytes12;
    assign fat_secs  = 11'((fat_bytes + 20'd511) >> 9);

    // Reserved, FAT and root sectors, and the minimum volume size
    assign meta_secs = 14'd1 + {3'd0, r_fat, 1'b0} + {2'd0, r_dir};
    assign need      = {1'b0, meta_secs} + 15'({7'd0, 8'd1} << r_sh);

    // Condition flags for the sequencer
    always_comb begin
        o_flags.invalid   = (r_heads == 16'd0) || (r_spt == 16'd0) ||
                            ((r_creq != 8'd0) && ((r_creq & (r_creq - 8'd1)) != 8'd0));
        o_flags.over16    = r_clus > FAT16_LIMIT;
        o_flags.small_vol = r_vsize < {17'd0, need};
        o_flags.no_retry  = !(r_fat16 && (r_clus <= FAT12_LIMIT));
        o_flags.exhaust   = r_retries >= RW'(MAX_RETRIES);
    end

    // Apply the operation of this step
    always_comb begin
        n_sh      = r_sh;
        n_roots   = r_roots;
        n_dir     = r_dir;
        n_clus    = r_clus;
        n_rem     = r_rem;
        n_fat     = r_fat;
        n_fat16   = r_fat16;
        n_retries = r_retries;
        n_err     = r_err;
        n_status  = r_status;
        unique case (i_op)
            OP_PREP: begin
                n_sh      = (r_creq == 8'd0) ? auto_sh : req_sh;
                n_roots   = roots_rnd;
                n_dir     = roots_rnd[15:4];
                n_retries = '0;
                n_err     = 1'b0;
            end
            OP_DIV: begin
                n_clus = r_vsize >> r_sh;
            end
            OP_FATSZ: begin
                n_fat   = fat_secs[9:0];
                n_fat16 = r_clus > FAT12_LIMIT;
            end
            OP_REMAIN: begin
                n_rem = r_vsize - {18'd0, meta_secs};
            end
            OP_FINAL: begin
                n_clus = r_rem >> r_sh;
            end
            OP_ADJUST: begin
                n_retries = r_retries + RW'(1);
                n_sh      = (r_sh == 3'd7) ? 3'd6 : r_sh + 3'd1;
            end
            OP_ERR_INV: begin
                n_err    = 1'b1;
                n_status = STAT_INVALID;
            end
            OP_ERR_MANY: begin
                n_err    = 1'b1;
                n_status = STAT_TOO_MANY;
            end
            OP_ERR_SMALL: begin
                n_err    = 1'b1;
                n_status = STAT_TOO_SMALL;
            end
            OP_ERR_CONV: begin
                n_err    = 1'b1;
                n_status = STAT_NO_CONV;
            end
            OP_NOP, OP_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sh      <= n_sh;
        r_roots   <= n_roots;
        r_dir     <= n_dir;
        r_clus    <= n_clus;
        r_rem     <= n_rem;
        r_fat     <= n_fat;
        r_fat16   <= n_fat16;
        r_retries <= n_retries;
        r_status  <= n_status;
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else begin
            r_err <= n_err;
        end
    end

    // Result fields; an error clears all but the status
    assign start_hard = r_vstart != 32'd0;
    assign res_status = r_err ? r_status : (r_fat16 ? STAT_FAT16 : STAT_FAT12);

    always_comb begin
        o_status              = res_status;
        o_sectors_per_cluster = '0;
        o_root_entries        = '0;
        o_fat_sectors         = '0;
        o_root_dir_sectors    = '0;
        o_fat_first_sector    = '0;
        o_cluster_count       = '0;
        o_hidden_sectors      = '0;
        o_media_code          = '0;
        o_drive_number        = '0;
        o_fat_head_word       = '0;
        if (!r_err) begin
            o_sectors_per_cluster = 8'd1 << r_sh;
            o_root_entries        = r_roots;
            o_fat_sectors         = r_fat;
            o_root_dir_sectors    = r_dir;
            o_fat_first_sector    = r_vstart + 32'd1;
            o_cluster_count       = r_clus[15:0];
            o_hidden_sectors      = r_vstart + r_hoff;
            o_media_code          = start_hard ? MEDIA_HARD : MEDIA_FLOPPY;
            o_drive_number        = start_hard ? DRIVE_HARD : DRIVE_FLOPPY;
            o_fat_head_word       = (r_fat16 ? HEAD_FAT16 : HEAD_FAT12) |
                                    {24'd0, o_media_code};
        end
    end

endmodule

FILE: hdl/fvl_seq.sv
// Microcode sequencer of the FAT layout calculator: step counter, ROM and jumps.
// Depends on fvl_pkg for the control word format and the program.
module fvl_seq
    import fvl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_out_busy,
    input  t_dp_flags i_flags,
    output t_ctrl     o_ctrl
);

    typedef enum logic [1:0] {
        SQ_IDLE = 2'b01,
        SQ_RUN  = 2'b10
    } t_seq_state;

    t_seq_state r_state, n_state;
    t_step      r_step, n_step;
    t_uword     uword;
    logic       take;

    // Fetch the control word of the current step
    assign uword = fvl_ucode(r_step);

    // Evaluate the jump condition
    always_comb begin
        unique case (uword.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_INVALID:  take = i_flags.invalid;
            C_OVER16:   take = i_flags.over16;
            C_SMALL:    take = i_flags.small_vol;
            C_NO_RETRY: take = i_flags.no_retry;
            C_EXHAUST:  take = i_flags.exhaust;
            C_OUT_BUSY: take = i_out_busy;
            default:    take = 1'b0;
        endcase
    end

    // Advance, jump or finish
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    n_state = SQ_RUN;
                    n_step  = S_PREP;
                end
            end
            SQ_RUN: begin
                if (take) begin
                    n_step = uword.target;
                end else if (uword.last) begin
                    n_state = SQ_IDLE;
                end else begin
                    n_step = 4'(r_step + 4'd1);
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_step  <= S_PREP;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Drive the datapath only while a program runs
    assign o_ctrl.busy = r_state == SQ_RUN;
    assign o_ctrl.op   = (r_state == SQ_RUN) ? uword.op : OP_NOP;

endmodule
